// ----- rtl/mexpdiv_pkg.sv -----
// Shared constants for the modular exponent and divide block.
`timescale 1ns / 1ps
`default_nettype none

package mexpdiv_pkg;

  // Width of the operand and result ports and of the modulus write data.
  localparam int unsigned DATA_W = 32;

  // Modulus held after reset.
  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd1000000007;

  // Operation codes carried on the opcode port.
  localparam logic OP_POWER  = 1'b0;
  localparam logic OP_DIVIDE = 1'b1;

endpackage : mexpdiv_pkg

`default_nettype wire

// ----- rtl/modular_exponent_and_divide_top.sv -----
// Modular power and Fermat-inverse division on one shared bit-serial modular multiplier.
// From acceptance to out_valid: reduce the operand mod m, then per exponent bit test it,
// multiply it in when it is set and square (no squaring after the top bit), then finish;
// divide mode also reduces the dividend and multiplies once more. Power with exponent zero
// or a zero modulus skips to the finish. One transaction at a time: none taken until done.
// Synchronous active-high reset idles the sequencer, drops out_valid and loads 1000000007.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponent_and_divide_top #(
  parameter int unsigned MOD_WIDTH = 32,
  parameter int unsigned EXP_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mexpdiv_pkg::DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           opcode,
  input  wire logic [mexpdiv_pkg::DATA_W-1:0] operand_a,
  input  wire logic [mexpdiv_pkg::DATA_W-1:0] operand_b,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mexpdiv_pkg::DATA_W-1:0]      result
);

  import mexpdiv_pkg::*;

  localparam int unsigned E_W   = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
  localparam int unsigned Y_W   = (DATA_W > MOD_WIDTH) ? DATA_W : MOD_WIDTH;
  localparam int unsigned CNT_W = $clog2(Y_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_BASE,
    S_POW,
    S_MUL_ACC,
    S_MUL_SQ,
    S_RED_A,
    S_FINAL_MUL,
    S_FINISH
  } state_t;

  state_t               state;
  logic [MOD_WIDTH-1:0] modulus;
  logic                 op;
  logic [DATA_W-1:0]    a_hold;
  logic [E_W-1:0]       expo;
  logic [MOD_WIDTH-1:0] pacc;
  logic [MOD_WIDTH-1:0] sq;

  // Shared bit-serial modular unit: each step doubles the accumulator, brings in one bit
  // (reduction) or adds the multiplicand when the multiplier bit is set, and reduces mod m.
  logic [MOD_WIDTH-1:0] u_acc;
  logic [MOD_WIDTH-1:0] u_x;
  logic [Y_W-1:0]       u_y;
  logic [CNT_W-1:0]     u_cnt;
  logic                 u_reduce;
  logic [MOD_WIDTH-1:0] u_acc_next;

  logic                 u_bit;
  logic [MOD_WIDTH:0]   m_ext;
  logic [MOD_WIDTH:0]   dbl;
  logic [MOD_WIDTH:0]   dbl_red;
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH:0]   sum_red;

  logic                 in_fire;
  logic [E_W-1:0]       expo_in;
  logic [MOD_WIDTH-1:0] one_mod;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    u_bit   = u_y[Y_W-1];
    m_ext   = {1'b0, modulus};
    dbl     = {u_acc, (u_reduce && u_bit)};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = dbl_red + ((!u_reduce && u_bit) ? {1'b0, u_x} : '0);
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    u_acc_next = sum_red[MOD_WIDTH-1:0];
  end

  always_comb begin
    if (opcode == OP_DIVIDE) begin
      expo_in = (modulus >= MOD_WIDTH'(2)) ? E_W'(modulus - MOD_WIDTH'(2)) : '0;
    end else begin
      expo_in = E_W'(EXP_WIDTH'(operand_b));
    end
    one_mod = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      u_cnt     <= '0;
      modulus   <= MOD_WIDTH'(MODULUS_RESET);
    end else begin
      if (cfg_valid) begin
        modulus <= MOD_WIDTH'(cfg_data);
      end
      // In the finishing step a new result takes the place of the one being accepted.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      if (u_cnt != '0) begin
        u_acc <= u_acc_next;
        u_y   <= u_y << 1;
        u_cnt <= u_cnt - CNT_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            op     <= opcode;
            a_hold <= operand_a;
            expo   <= expo_in;
            if (modulus == '0) begin
              pacc  <= '0;
              state <= S_FINISH;
            end else if (opcode == OP_POWER && expo_in == '0) begin
              pacc  <= MOD_WIDTH'(1);
              state <= S_FINISH;
            end else begin
              pacc     <= one_mod;
              // Reduce the base (operand a) or the divisor (operand b) modulo m.
              u_acc    <= '0;
              u_x      <= '0;
              u_y      <= Y_W'((opcode == OP_DIVIDE) ? operand_b : operand_a) << (Y_W - DATA_W);
              u_cnt    <= CNT_W'(DATA_W);
              u_reduce <= 1'b1;
              state    <= S_RED_BASE;
            end
          end
        end

        S_RED_BASE: begin
          if (u_cnt == '0) begin
            sq    <= u_acc;
            state <= S_POW;
          end
        end

        S_POW: begin
          if (expo == '0) begin
            if (op == OP_DIVIDE) begin
              u_acc    <= '0;
              u_x      <= '0;
              u_y      <= Y_W'(a_hold) << (Y_W - DATA_W);
              u_cnt    <= CNT_W'(DATA_W);
              u_reduce <= 1'b1;
              state    <= S_RED_A;
            end else begin
              state <= S_FINISH;
            end
          end else if (expo[0]) begin
            u_acc    <= '0;
            u_x      <= pacc;
            u_y      <= Y_W'(sq) << (Y_W - MOD_WIDTH);
            u_cnt    <= CNT_W'(MOD_WIDTH);
            u_reduce <= 1'b0;
            state    <= S_MUL_ACC;
          end else begin
            expo     <= expo >> 1;
            u_acc    <= '0;
            u_x      <= sq;
            u_y      <= Y_W'(sq) << (Y_W - MOD_WIDTH);
            u_cnt    <= CNT_W'(MOD_WIDTH);
            u_reduce <= 1'b0;
            state    <= S_MUL_SQ;
          end
        end

        S_MUL_ACC: begin
          if (u_cnt == '0) begin
            pacc <= u_acc;
            expo <= expo >> 1;
            // The squaring after the last set bit would never be used, so it is skipped.
            if ((expo >> 1) == '0) begin
              state <= S_POW;
            end else begin
              u_acc    <= '0;
              u_x      <= sq;
              u_y      <= Y_W'(sq) << (Y_W - MOD_WIDTH);
              u_cnt    <= CNT_W'(MOD_WIDTH);
              u_reduce <= 1'b0;
              state    <= S_MUL_SQ;
            end
          end
        end

        S_MUL_SQ: begin
          if (u_cnt == '0) begin
            sq    <= u_acc;
            state <= S_POW;
          end
        end

        S_RED_A: begin
          if (u_cnt == '0) begin
            u_acc    <= '0;
            u_x      <= pacc;
            u_y      <= Y_W'(u_acc) << (Y_W - MOD_WIDTH);
            u_cnt    <= CNT_W'(MOD_WIDTH);
            u_reduce <= 1'b0;
            state    <= S_FINAL_MUL;
          end
        end

        S_FINAL_MUL: begin
          if (u_cnt == '0) begin
            pacc  <= u_acc;
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid || out_ready) begin
            result    <= DATA_W'(pacc);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The shared unit keeps its accumulator reduced on every step.
  a_unit_reduced: assert property (@(posedge clk) disable iff (rst)
    (u_cnt != '0) |-> (u_acc < modulus))
    else $error("modular unit accumulator not below the modulus");

  // Both running values are reduced whenever an exponent bit is examined.
  a_pow_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_POW) |-> (sq < modulus && pacc < modulus))
    else $error("power loop operands not below the modulus");

  // Once a transaction is taken the block stays busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted again straight after a transaction");

  // A result appears only from the finishing step of the sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside the finishing step");

endmodule : modular_exponent_and_divide_top

`default_nettype wire

// ----- sim/tb_modular_exponent_and_divide_top.sv -----
// Self-checking testbench for the modular power and divide block.
`timescale 1ns / 1ps

module tb_modular_exponent_and_divide_top;
  import mexpdiv_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              opcode = OP_POWER;
  logic [DATA_W-1:0] operand_a = '0;
  logic [DATA_W-1:0] operand_b = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] result;

  logic [DATA_W-1:0] pending_results[$];
  logic [DATA_W-1:0] modulus_copy = MODULUS_RESET;
  int unsigned       fail_count = 0;
  int unsigned       stall_left = 0;
  bit                quiet_mode = 1'b0;

  modular_exponent_and_divide_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Right-to-left square and multiply; products of two words fit in 64 bits exactly.
  function automatic logic [DATA_W-1:0] powmod_word(input logic [DATA_W-1:0] base,
                                                    input logic [DATA_W-1:0] ex,
                                                    input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] e;
    if (ex == 0) return DATA_W'(1);
    acc = 64'd1 % m;
    sq  = 64'(base) % m;
    e   = 64'(ex);
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % m;
      e  = e >> 1;
      sq = (sq * sq) % m;
    end
    return acc[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] predict_result(input logic op,
                                                       input logic [DATA_W-1:0] a,
                                                       input logic [DATA_W-1:0] b);
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] am;
    m = 64'(modulus_copy);
    if (m == 0) return '0;
    if (op == OP_POWER) return powmod_word(a, b, m);
    // Fermat inverse of the divisor, then one multiply with the reduced dividend.
    e  = (m >= 64'd2) ? m - 64'd2 : 64'd0;
    p  = 64'(powmod_word(b, e[DATA_W-1:0], m)) % m;
    am = 64'(a) % m;
    return DATA_W'((am * p) % m);
  endfunction

  // Mostly no gap, some short ones and the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand(input logic [DATA_W-1:0] m);
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      3: return $urandom_range(0, 15);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      5: return m - 1 + $urandom_range(0, 2);
      6: return m * $urandom_range(0, 3);
      7: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Exponents of random bit length keep most power transactions short.
  function automatic logic [DATA_W-1:0] pick_exponent();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return '0;
      1: return $urandom_range(1, 3);
      2: return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_operation(input logic op, input logic [DATA_W-1:0] a,
                                input logic [DATA_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    pending_results.insert(pending_results.size(), predict_result(op, a, b));
    do @(posedge clk); while (!in_ready);
  endtask

  // Always advances at least one edge, so in_valid is never assigned twice in one step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_modulus(input logic [DATA_W-1:0] value);
    wait_for_results();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    modulus_copy = value;
  endtask

  task automatic send_random(input int unsigned count, input int unsigned divide_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < divide_pct) ? OP_DIVIDE : OP_POWER;
      if (op == OP_POWER) send_operation(op, pick_operand(modulus_copy), pick_exponent());
      else send_operation(op, pick_operand(modulus_copy), pick_operand(modulus_copy));
    end
  endtask

  task automatic test_directed_cases();
    // Reset modulus first, so the reset value of the register is checked too.
    send_operation(OP_POWER, 32'd0, 32'd0);
    send_operation(OP_POWER, 32'hFFFF_FFFF, 32'd0);
    send_operation(OP_POWER, 32'd0, 32'hFFFF_FFFF);
    send_operation(OP_POWER, 32'd2, 32'd10);
    send_operation(OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(OP_POWER, 32'd1000000006, 32'd2);
    send_operation(OP_DIVIDE, 32'd10, 32'd2);
    send_operation(OP_DIVIDE, 32'd10, 32'd0);
    send_operation(OP_DIVIDE, 32'd5, 32'd1000000007);
    send_operation(OP_DIVIDE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(OP_DIVIDE, 32'd0, 32'd7);
    // With a modulus of one, exponent zero still gives one and division gives zero.
    write_modulus(32'd1);
    send_operation(OP_POWER, 32'd7, 32'd0);
    send_operation(OP_POWER, 32'd7, 32'd3);
    send_operation(OP_DIVIDE, 32'd5, 32'd3);
    send_operation(OP_DIVIDE, 32'd0, 32'd0);
    // With a modulus of two the inverse exponent is zero, so division returns a mod 2.
    write_modulus(32'd2);
    send_operation(OP_DIVIDE, 32'd7, 32'd3);
    send_operation(OP_DIVIDE, 32'd6, 32'd4);
    send_operation(OP_DIVIDE, 32'd7, 32'd0);
    send_operation(OP_POWER, 32'd3, 32'd5);
    write_modulus(32'hFFFF_FFFF);
    send_operation(OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(OP_POWER, 32'hFFFF_FFFE, 32'd2);
    send_operation(OP_DIVIDE, 32'd12345, 32'hFFFF_FFFE);
    write_modulus(32'd4294967291);
    send_operation(OP_DIVIDE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operation(OP_POWER, 32'd2, 32'hFFFF_FFFA);
  endtask

  task automatic test_fixed_moduli();
    logic [DATA_W-1:0] moduli[9];
    moduli = '{32'd1000000007, 32'd4294967291, 32'hFFFF_FFFF, 32'd65521, 32'd251,
               32'd7, 32'd3, 32'd2, 32'd1};
    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      quiet_mode = (k == 3);
      send_random(150, 30);
    end
    wait_for_results();
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_moduli();
    logic [DATA_W-1:0] m;
    for (int k = 0; k < 8; k++) begin
      m = $urandom >> $urandom_range(0, 28);
      if (m == 0) m = 1;
      write_modulus(m);
      send_random(40, 40);
    end
  endtask

  task automatic test_drain_pause();
    write_modulus(32'd1000000007);
    for (int k = 0; k < 6; k++) begin
      send_random(25, 30);
      // Hold off until the block has returned everything in flight.
      wait_for_results();
    end
  endtask

  always @(posedge clk) begin : result_check
    logic [DATA_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result %h with nothing pending", result);
      end else begin
        want = pending_results.pop_front();
        if (result !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result mismatch: expected %h, actual %h", want, result);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      if (stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left--;
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_fixed_moduli();
    test_random_moduli();
    test_drain_pause();
    wait_for_results();
    repeat (2500) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- modular_exponent_and_divide_top.f -----
rtl/mexpdiv_pkg.sv
rtl/modular_exponent_and_divide_top.sv
sim/tb_modular_exponent_and_divide_top.sv
